// ===== hdl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  localparam int CAP_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register indexes
  localparam logic [ADDR_W-3:0] REG_OUT_CAPACITY = '0;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_BAD  = 2'd2
  } char_kind_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  // classified character as it sits in the queue
  typedef struct packed {
    char_kind_t  kind;
    logic [5:0]  sextet;
    logic        last;
  } q_entry_t;

  // one result beat
  typedef struct packed {
    logic [CAP_W-1:0] byte_count;
    status_t          status;
    logic             done_res;
    logic             byte_valid;
    logic [7:0]       out_byte;
  } result_t;

  // classify a raw character: kind and six-bit value
  function automatic q_entry_t classify(input logic [7:0] c, input logic last);
    q_entry_t e;
    e.last   = last;
    e.sextet = '0;
    e.kind   = KIND_DATA;
    if (c >= 8'h41 && c <= 8'h5A) begin
      e.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      e.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      e.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      e.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      e.sextet = 6'd63;
    end else if (c == PAD_CHAR) begin
      e.kind = KIND_PAD;
    end else begin
      e.kind = KIND_BAD;
    end
    return e;
  endfunction

endpackage

// ===== hdl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character beats, classifies them and holds one classified entry.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  output logic       f_valid,
  input  logic       f_ready,
  output q_entry_t   f_entry
);

  logic     hold_valid;
  q_entry_t hold_entry;

  assign s_tready = !hold_valid || f_ready;
  assign f_valid  = hold_valid;
  assign f_entry  = hold_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_entry <= classify(s_tdata, s_tlast);
    end
  end

endmodule

// ===== hdl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_entry
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== hdl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Bit accumulator, byte emission, error latching and the output register.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] out_capacity,
  input  logic             q_valid,
  output logic             q_ready,
  input  q_entry_t         q_entry,
  output logic             m_valid,
  input  logic             m_ready,
  output result_t          m_result
);

  logic [5:0]       bit_store;
  logic [2:0]       bits_held;
  logic [CAP_W-1:0] bytes_out;
  logic             pad_seen;
  status_t          error_code;

  logic [5:0]       bit_store_next;
  logic [2:0]       bits_held_next;
  logic [CAP_W-1:0] bytes_out_next;
  logic             pad_seen_next;
  status_t          error_code_next;

  // status beat waiting behind a byte beat of the same character
  logic             pend;
  result_t          pend_result;
  logic             pend_next;
  result_t          pend_result_next;

  logic             ovalid;
  result_t          ores;
  logic             ovalid_next;
  result_t          ores_next;

  logic             out_free;
  logic             take;
  logic [11:0]      acc;
  logic [3:0]       held;
  logic [3:0]       held_rem;
  logic [11:0]      acc_shift;
  logic             emit_byte;
  result_t          byte_res;
  result_t          done_res;

  assign out_free = !ovalid || m_ready;
  assign q_ready  = !pend && out_free;
  assign take     = q_valid && q_ready;
  assign m_valid  = ovalid;
  assign m_result = ores;

  assign acc       = {bit_store, q_entry.sextet};
  assign held      = {1'b0, bits_held} + 4'd6;
  assign held_rem  = held - 4'd8;
  assign acc_shift = acc >> held_rem;

  always_comb begin
    bit_store_next   = bit_store;
    bits_held_next   = bits_held;
    bytes_out_next   = bytes_out;
    pad_seen_next    = pad_seen;
    error_code_next  = error_code;
    pend_next        = pend;
    pend_result_next = pend_result;
    ovalid_next      = ovalid;
    ores_next        = ores;
    emit_byte        = 1'b0;

    byte_res            = '0;
    byte_res.byte_valid = 1'b1;
    byte_res.out_byte   = acc_shift[7:0];

    if (take && error_code == ST_OK && !pad_seen) begin
      unique case (q_entry.kind)
        KIND_PAD: pad_seen_next = 1'b1;
        KIND_BAD: error_code_next = ST_BAD;
        KIND_DATA: begin
          if (held >= 4'd8) begin
            bits_held_next = held_rem[2:0];
            if (bytes_out >= out_capacity) begin
              error_code_next = ST_OVF;
            end else begin
              emit_byte      = 1'b1;
              bytes_out_next = bytes_out + 1'b1;
            end
          end else begin
            bits_held_next = held[2:0];
          end
          bit_store_next = acc[5:0];
        end
        default: error_code_next = ST_BAD;
      endcase
    end

    done_res            = '0;
    done_res.done_res   = 1'b1;
    done_res.status     = error_code_next;
    done_res.byte_count = bytes_out_next;

    if (out_free) begin
      ovalid_next = 1'b0;
    end

    if (pend && out_free) begin
      ovalid_next = 1'b1;
      ores_next   = pend_result;
      pend_next   = 1'b0;
    end else if (take) begin
      if (emit_byte) begin
        ovalid_next = 1'b1;
        ores_next   = byte_res;
        if (q_entry.last) begin
          pend_next        = 1'b1;
          pend_result_next = done_res;
        end
      end else if (q_entry.last) begin
        ovalid_next = 1'b1;
        ores_next   = done_res;
      end
    end

    // end of text: decoder starts over
    if (take && q_entry.last) begin
      bit_store_next  = '0;
      bits_held_next  = '0;
      bytes_out_next  = '0;
      pad_seen_next   = 1'b0;
      error_code_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store  <= '0;
      bits_held  <= '0;
      bytes_out  <= '0;
      pad_seen   <= 1'b0;
      error_code <= ST_OK;
      pend       <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      bit_store  <= bit_store_next;
      bits_held  <= bits_held_next;
      bytes_out  <= bytes_out_next;
      pad_seen   <= pad_seen_next;
      error_code <= error_code_next;
      pend       <= pend_next;
      ovalid     <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_result <= pend_result_next;
    ores        <= ores_next;
  end

endmodule

// ===== hdl/base64_decoder.sv =====
// Character path: front hold register, queue slot, back-end output register.
// Throughput: one character per cycle unless output stalls or a status beat
//   is pending; a character that yields both a byte and the final status takes
//   two output beats. A 4-entry queue absorbs output stalls.
// Reset: synchronous, active high; clears decoder state, queue and outputs,
//   and sets out_capacity to 65535. No clearing pass.
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming Base64 decoder, one character per beat, APB capacity register.
// ----------------------------------------------------------------------------
module base64_decoder import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_char
  input  logic              s_tlast,   // is_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [7:0] out_byte, [9:8] status,
                                       // [25:10] byte_count, [31:26] zero
  output logic              m_tlast,   // done_res
  output logic              m_tuser,   // [0] byte_valid
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic             f_valid;
  logic             f_ready;
  q_entry_t         f_entry;
  logic             q_valid;
  logic             q_ready;
  q_entry_t         q_entry;
  result_t          res;
  logic [CAP_W-1:0] out_capacity;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_OUT_CAPACITY);
  assign prdata  = reg_hit ? DATA_W'(out_capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= '1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      out_capacity <= pwdata[CAP_W-1:0];
    end
  end

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_entry  (f_entry)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .out_capacity (out_capacity),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_entry      (q_entry),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .m_result     (res)
  );

  assign m_tdata = {6'd0, res.byte_count, res.status, res.out_byte};
  assign m_tlast = res.done_res;
  assign m_tuser = res.byte_valid;

endmodule

// ===== hdl/b64d_chk.sv =====
// ----------------------------------------------------------------------------
// b64d_chk
// Port-level checks for the Base64 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_chk (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [31:0]       m_tdata,
  input logic              m_tlast,
  input logic              m_tuser
);

  // a status beat never carries a byte, a byte beat is never the status
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast != m_tuser))
    else $error("result beat is neither a byte nor a status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[9:8] != 2'd3))
    else $error("undefined status code");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[25:8] == '0))
    else $error("byte beat has status or count set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

endmodule

bind base64_decoder b64d_chk u_chk (.*);

// ===== bench/b64d_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64d_checker
// Watches the character, result and APB traffic of the Base64 decoder, decodes
// each accepted character itself and compares every result beat field by field.
// ----------------------------------------------------------------------------
module b64d_checker import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_char
  input  logic              s_tlast,   // is_last
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [31:0]       m_tdata,   // [7:0] out_byte, [9:8] status,
                                       // [25:10] byte_count, [31:26] zero
  input  logic              m_tlast,   // done_res
  input  logic              m_tuser,   // [0] byte_valid
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  logic [6:0]       sextet_lut [256];  // [6] set for alphabet characters
  logic [CAP_W-1:0] cap_limit;
  logic [11:0]      acc_bits;
  logic [2:0]       acc_held;
  logic [15:0]      emitted;
  logic             pad_hit;
  status_t          latched;
  result_t          want_beats [$];
  result_t          head;
  int               fails = 0;

  initial begin
    for (int i = 0; i < 256; i++) sextet_lut[8'(i)] = '0;
    for (int i = 0; i < 26; i++) begin
      sextet_lut[8'("A" + i)] = {1'b1, 6'(i)};
      sextet_lut[8'("a" + i)] = {1'b1, 6'(i + 26)};
    end
    for (int i = 0; i < 10; i++) sextet_lut[8'("0" + i)] = {1'b1, 6'(i + 52)};
    sextet_lut[8'("+")] = {1'b1, 6'd62};
    sextet_lut[8'("/")] = {1'b1, 6'd63};
  end

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    if (fails < 40) $display("%0t ns: mismatch on %s, got %0h want %0h",
                             $time, what, got, want);
    fails++;
  endtask

  task automatic clear_text();
    acc_bits = '0;
    acc_held = '0;
    emitted  = '0;
    pad_hit  = 1'b0;
    latched  = ST_OK;
  endtask

  // one character in, zero to two result beats queued
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [11:0] acc;
    logic [3:0]  held;
    result_t     r;
    if (latched == ST_OK && !pad_hit) begin
      if (c == PAD_CHAR) begin
        pad_hit = 1'b1;
      end else if (!sextet_lut[c][6]) begin
        latched = ST_BAD;
      end else begin
        acc  = {acc_bits[5:0], sextet_lut[c][5:0]};
        held = acc_held + 4'd6;
        if (held >= 4'd8) begin
          held -= 4'd8;
          if (emitted >= cap_limit) begin
            latched = ST_OVF;
          end else begin
            r = '0;
            r.out_byte   = 8'(acc >> held);
            r.byte_valid = 1'b1;
            want_beats.push_back(r);
            emitted++;
          end
        end
        acc_bits = acc;
        acc_held = held[2:0];
      end
    end
    if (last) begin
      r = '0;
      r.done_res   = 1'b1;
      r.status     = latched;
      r.byte_count = emitted;
      want_beats.push_back(r);
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cap_limit = '1;
      clear_text();
      want_beats.delete();
    end else begin
      // results of a character come cycles later, so compare before predicting
      if (m_tvalid && m_tready) begin
        if (want_beats.size() == 0) begin
          report("unexpected result beat", m_tdata, '0);
        end else begin
          head = want_beats.pop_front();
          if (m_tdata[7:0] !== head.out_byte)
            report("out_byte", 32'(m_tdata[7:0]), 32'(head.out_byte));
          if (m_tuser !== head.byte_valid)
            report("byte_valid", 32'(m_tuser), 32'(head.byte_valid));
          if (m_tlast !== head.done_res)
            report("done_res", 32'(m_tlast), 32'(head.done_res));
          if (m_tdata[9:8] !== head.status)
            report("status", 32'(m_tdata[9:8]), 32'(head.status));
          if (m_tdata[25:10] !== head.byte_count)
            report("byte_count", 32'(m_tdata[25:10]), 32'(head.byte_count));
          if (m_tdata[31:26] !== '0) report("tdata fill", 32'(m_tdata[31:26]), '0);
        end
      end
      if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_OUT_CAPACITY) begin
        if (pwrite) begin
          cap_limit = pwdata[CAP_W-1:0];
        end else if (prdata !== DATA_W'(cap_limit)) begin
          report("out_capacity readback", prdata, DATA_W'(cap_limit));
        end
      end
    end
    pending    <= want_beats.size();
    fail_count <= fails;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives Base64 texts into the decoder: a directed set of corner texts, then
// random well-formed, broken and noise texts under several output capacities,
// with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import b64d_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 110;
  localparam int SQUEEZE_LEN  = 300;
  localparam logic [ADDR_W-1:0] ADDR_CAP   = {REG_OUT_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_CAP + ADDR_W'(4);

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;   // [7:0] text_char
  logic              s_tlast  = 1'b0; // is_last
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;         // [7:0] out_byte, [9:8] status, [25:10] byte_count
  logic              m_tlast;         // done_res
  logic              m_tuser;         // [0] byte_valid
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int               fail_count;
  int               pending;
  int               idle_run = 0;
  int               sent = 0;
  bit               squeeze_go = 1'b0;
  logic [CAP_W-1:0] cap_plan [8];

  always #5 clk = ~clk;

  base64_decoder uut (.*);
  b64d_checker   chk (.*);

  function automatic logic [7:0] b64_char(input int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == "+" || c == "/" || c == PAD_CHAR);
    return c;
  endfunction

  // offer one character, then an optional gap
  task automatic send_char(input logic [7:0] c, input logic last);
    int r;
    int gap;
    s_tdata  <= c;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    r   = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) :
          (r < 98) ? $urandom_range(4, 10) : $urandom_range(20, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic random_text();
    logic [7:0] txt [$];
    int r;
    int groups;
    int tail;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
      repeat (groups * 4) txt.push_back(b64_char($urandom_range(0, 63)));
      tail = $urandom_range(0, 5);
      case (tail)
        1: begin
          repeat (2) txt.push_back(b64_char($urandom_range(0, 63)));
          repeat (2) txt.push_back(PAD_CHAR);
        end
        2: begin
          repeat (3) txt.push_back(b64_char($urandom_range(0, 63)));
          txt.push_back(PAD_CHAR);
        end
        3: repeat (2) txt.push_back(b64_char($urandom_range(0, 63)));
        4: repeat (3) txt.push_back(b64_char($urandom_range(0, 63)));
        5: txt.push_back(b64_char($urandom_range(0, 63)));
        default: ;
      endcase
      // junk after the padding is ignored by the decoder
      if ((tail == 1 || tail == 2) && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
      if (txt.size() == 0) txt.push_back(b64_char($urandom_range(0, 63)));
      if (r >= 93) txt[$urandom_range(0, txt.size() - 1)] = PAD_CHAR;
      else if (r >= 85) txt[$urandom_range(0, txt.size() - 1)] = bad_char();
    end
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drop valid and wait until every result of the texts sent has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int goal;
    cap_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd4, 16'($urandom_range(3, 30)), 16'd2,
                 16'($urandom_range(0, 65535)), 16'hFFFF};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    apb_access(1'b0, ADDR_CAP, '0);

    send_str("TWFu");
    send_str("////");
    send_str("QUI=");
    send_str("+/9z");
    send_str("A");          // leftover bits dropped
    send_str("=");          // pad alone
    send_char(8'h00, 1'b0); // NUL is not in the alphabet
    send_char("A", 1'b1);
    send_char(8'hFF, 1'b1);
    send_str("AB=C");       // character after pad ignored

    foreach (cap_plan[p]) begin
      settle();
      if (p == 3) apb_access(1'b1, ADDR_SPARE, $urandom);
      apb_access(1'b1, ADDR_CAP, {16'($urandom), cap_plan[p]});
      apb_access(1'b0, ADDR_CAP, '0);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        random_text();
        if (sent > 70) squeeze_go = 1'b1;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold while characters keep coming
  initial begin
    int r;
    int n;
    bit squeezed;
    squeezed = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_go && !squeezed) begin
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 24);
      end else begin
        m_tready <= 1'b0;
        n = (r < 90) ? $urandom_range(1, 3) : (r < 98) ? $urandom_range(4, 12) :
            $urandom_range(30, 120);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
